FILE: rtl/core/lebm_pkg.sv
// Shared types and constants for the lidar edge board matcher.
// Holds the transfer payload structs, slot record layout and code values.
// No dependencies.
package lebm_pkg;

    // Widths of the register port.
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_SCAN_POINTS    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_EDGE_JUMP      = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MATCH_ANGLE    = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MATCH_DISTANCE = 8'd3;

    // Register reset values.
    localparam logic [15:0] SCAN_POINTS_RST    = 16'd360;
    localparam logic [15:0] EDGE_JUMP_RST      = 16'd200;
    localparam logic [15:0] MATCH_ANGLE_RST    = 16'd1000;
    localparam logic [15:0] MATCH_DISTANCE_RST = 16'd100;

    // Range code for a missing return, and angle limits.
    localparam logic [15:0] NO_RETURN       = 16'hFFFF;
    localparam logic [15:0] FULL_TURN_CDEG  = 16'd36000;
    localparam logic [15:0] MAX_ANGLE_CDEG  = 16'd35999;

    // Result event codes.
    localparam logic [1:0] EVT_NEW_BOARD  = 2'd0;
    localparam logic [1:0] EVT_COMPLETED  = 2'd1;
    localparam logic [1:0] EVT_TABLE_FULL = 2'd2;

    // One input sample.
    typedef struct packed {
        logic [15:0] range_mm;
        logic        last_in_scan;
    } lebm_in_t;

    // One result item.
    typedef struct packed {
        logic [1:0]  event_kind;
        logic [15:0] board_id;
        logic        edge_is_left;
        logic [15:0] left_angle_cdeg;
        logic [15:0] left_distance_mm;
        logic [15:0] right_angle_cdeg;
        logic [15:0] right_distance_mm;
    } lebm_out_t;

    // One stored edge: angle and range.
    typedef struct packed {
        logic [15:0] angle_cdeg;
        logic [15:0] distance_mm;
    } lebm_edge_t;

    // One board record in the slot memory.
    typedef struct packed {
        logic [15:0] identifier;
        lebm_edge_t  left_edge;
        lebm_edge_t  right_edge;
    } lebm_slot_t;

    // Handshake between the sequencer and the divider.
    typedef struct packed {
        logic busy;
        logic done;
    } lebm_div_status_t;

endpackage

FILE: rtl/core/lidar_edge_board_matcher_unit.sv
// Top level of the lidar edge board matcher: edge detection, angle unit and slot memory.
// Depends on lebm_pkg and lebm_divider.
//
// The block takes one range sample per transfer. A sample that forms no edge is
// absorbed while idle and the next one is accepted right after. A sample that forms
// an edge first gets its angle (a multiply step, a divider start step, 32 bit-serial
// divide steps by scan_points and a handoff step), then a walk over the board slots
// that passes each empty or completed slot and reads each open slot from the slot
// memory before its check, stopping at the first match or past the last slot, then
// a commit step that writes back and loads the result. No further sample is accepted
// before that commit, which waits while an earlier result still waits. The divider
// and the single-port slot memory set how long an edge takes. Each edge yields
// exactly one result transfer; the result register lets the next sample enter
// while a result waits.
module lidar_edge_board_matcher_unit
#(
    parameter int MAX_BOARDS = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  lebm_pkg::lebm_in_t                in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output lebm_pkg::lebm_out_t               out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lebm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lebm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import lebm_pkg::*;

    localparam int SLOT_W = (MAX_BOARDS > 1) ? $clog2(MAX_BOARDS) : 1;
    localparam int CNT_W  = $clog2(MAX_BOARDS + 1);

    // Sequencer state codes.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_DSTART = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_SCAN   = 3'd4;
    localparam logic [2:0] ST_CHECK  = 3'd5;
    localparam logic [2:0] ST_COMMIT = 3'd6;

    // Configuration registers.
    logic [15:0] scan_points_reg;
    logic [15:0] edge_jump_reg;
    logic [15:0] match_angle_reg;
    logic [15:0] match_distance_reg;

    // Sample history.
    logic [15:0] prev_filt_reg;
    logic [15:0] prev_raw_reg;
    logic [15:0] sample_index_reg;
    logic [15:0] next_board_reg;

    // Per-slot flags.
    logic [MAX_BOARDS-1:0] slot_used_reg;
    logic [MAX_BOARDS-1:0] slot_complete_reg;

    // Sequencer and edge registers.
    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic              is_left_reg;
    logic [15:0]       edge_idx_reg;
    logic [15:0]       edge_dist_reg;
    logic [15:0]       pts_reg;
    logic [31:0]       prod_reg;
    logic [15:0]       angle_reg;
    logic [CNT_W-1:0]  slot_cnt_reg;
    logic              hit_reg;
    logic              free_found_reg;
    logic [SLOT_W-1:0] free_slot_reg;

    // Result register.
    logic      out_valid_reg;
    lebm_out_t out_data_reg;

    // Slot memory.
    lebm_slot_t        slot_mem [MAX_BOARDS];
    lebm_slot_t        rd_data_reg;
    logic              mem_rd_en;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_addr;
    lebm_slot_t        mem_wr_data;

    // Divider interface.
    logic [31:0]      div_quotient;
    lebm_div_status_t div_status;
    logic             div_start;

    // Combinational helpers.
    logic              in_xfer;
    logic [15:0]       cur_filt;
    logic              prev_bad;
    logic              cur_bad;
    logic [15:0]       jump;
    logic              edge_found;
    logic [SLOT_W-1:0] cur_slot;
    lebm_edge_t        own_edge;
    lebm_edge_t        opp_edge;
    logic [15:0]       ang_diff;
    logic [15:0]       dist_diff;
    logic              side_hit;
    logic              can_load;
    lebm_out_t         result;
    logic [15:0]       quo_sat;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign can_load  = !out_valid_reg || out_ready;
    assign cur_slot  = slot_cnt_reg[SLOT_W-1:0];

    // Jump test between the previous and the current sample.
    always_comb
    begin
        cur_filt = (in_data.range_mm == 16'd0) ? NO_RETURN : in_data.range_mm;
        prev_bad = (prev_filt_reg == NO_RETURN);
        cur_bad  = (cur_filt == NO_RETURN);
        jump     = (prev_filt_reg > cur_filt) ? 16'(prev_filt_reg - cur_filt)
                                              : 16'(cur_filt - prev_filt_reg);
        if (sample_index_reg == 16'd0)
        begin
            edge_found = 1'b0;
        end
        else if (prev_bad || cur_bad)
        begin
            edge_found = prev_bad ^ cur_bad;
        end
        else
        begin
            edge_found = (jump > edge_jump_reg);
        end
    end

    // Tolerance test of the new edge against the opposite side of the slot read last.
    always_comb
    begin
        own_edge.angle_cdeg  = angle_reg;
        own_edge.distance_mm = edge_dist_reg;
        opp_edge  = is_left_reg ? rd_data_reg.right_edge : rd_data_reg.left_edge;
        ang_diff  = (angle_reg > opp_edge.angle_cdeg)
                    ? 16'(angle_reg - opp_edge.angle_cdeg)
                    : 16'(opp_edge.angle_cdeg - angle_reg);
        dist_diff = (edge_dist_reg > opp_edge.distance_mm)
                    ? 16'(edge_dist_reg - opp_edge.distance_mm)
                    : 16'(opp_edge.distance_mm - edge_dist_reg);
        side_hit  = (opp_edge.distance_mm != 16'd0) && (opp_edge.distance_mm != NO_RETURN)
                    && (edge_dist_reg != NO_RETURN)
                    && (ang_diff < match_angle_reg) && (dist_diff < match_distance_reg);
    end

    // Result item and write-back record for the commit step.
    always_comb
    begin
        result.edge_is_left = is_left_reg;
        mem_wr_data.identifier = next_board_reg;
        mem_wr_data.left_edge  = is_left_reg ? own_edge : '0;
        mem_wr_data.right_edge = is_left_reg ? '0 : own_edge;
        if (hit_reg)
        begin
            mem_wr_data.identifier = rd_data_reg.identifier;
            mem_wr_data.left_edge  = is_left_reg ? own_edge : rd_data_reg.left_edge;
            mem_wr_data.right_edge = is_left_reg ? rd_data_reg.right_edge : own_edge;
            result.event_kind      = EVT_COMPLETED;
            result.board_id        = rd_data_reg.identifier;
        end
        else if (free_found_reg)
        begin
            result.event_kind = EVT_NEW_BOARD;
            result.board_id   = next_board_reg;
        end
        else
        begin
            result.event_kind = EVT_TABLE_FULL;
            result.board_id   = '0;
        end
        result.left_angle_cdeg   = mem_wr_data.left_edge.angle_cdeg;
        result.left_distance_mm  = mem_wr_data.left_edge.distance_mm;
        result.right_angle_cdeg  = mem_wr_data.right_edge.angle_cdeg;
        result.right_distance_mm = mem_wr_data.right_edge.distance_mm;
    end

    // Sequencer next state and memory controls.
    always_comb
    begin
        state_next = state_reg;
        mem_rd_en  = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = cur_slot;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && edge_found)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DSTART;
            end
            ST_DSTART:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (slot_cnt_reg == CNT_W'(MAX_BOARDS))
                begin
                    state_next = ST_COMMIT;
                end
                else if (slot_used_reg[cur_slot] && !slot_complete_reg[cur_slot])
                begin
                    mem_rd_en  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = side_hit ? ST_COMMIT : ST_SCAN;
            end
            ST_COMMIT:
            begin
                if (can_load)
                begin
                    mem_we     = hit_reg || free_found_reg;
                    mem_addr   = hit_reg ? cur_slot : free_slot_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Divided angle, saturated to the last valid centidegree.
    assign quo_sat = (div_quotient > 32'(MAX_ANGLE_CDEG)) ? MAX_ANGLE_CDEG
                                                          : div_quotient[15:0];

    // Angle unit: index / scan_points after scaling by a full turn.
    lebm_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (pts_reg),
        .quotient (div_quotient),
        .status   (div_status)
    );

    // Slot memory: one read or one write per cycle, read data registered.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            rd_data_reg <= slot_mem[mem_addr];
        end
    end

    // Control state, configuration and history.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            scan_points_reg    <= SCAN_POINTS_RST;
            edge_jump_reg      <= EDGE_JUMP_RST;
            match_angle_reg    <= MATCH_ANGLE_RST;
            match_distance_reg <= MATCH_DISTANCE_RST;
            prev_filt_reg      <= NO_RETURN;
            prev_raw_reg       <= '0;
            sample_index_reg   <= '0;
            next_board_reg     <= 16'd1;
            slot_used_reg      <= '0;
            slot_complete_reg  <= '0;
            slot_cnt_reg       <= '0;
            hit_reg            <= 1'b0;
            free_found_reg     <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Register write transfer.
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_SCAN_POINTS:    scan_points_reg    <= cfg_data;
                    REG_EDGE_JUMP:      edge_jump_reg      <= cfg_data;
                    REG_MATCH_ANGLE:    match_angle_reg    <= cfg_data;
                    REG_MATCH_DISTANCE: match_distance_reg <= cfg_data;
                    default:            ;
                endcase
            end

            // Sample history updates on every input transfer.
            if (in_xfer)
            begin
                prev_filt_reg <= cur_filt;
                prev_raw_reg  <= in_data.range_mm;
                if (in_data.last_in_scan)
                begin
                    sample_index_reg <= '0;
                end
                else if (sample_index_reg != 16'hFFFF)
                begin
                    sample_index_reg <= 16'(sample_index_reg + 16'd1);
                end
            end

            // Slot walk bookkeeping.
            if (state_reg == ST_DIV && div_status.done)
            begin
                slot_cnt_reg   <= '0;
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (state_reg == ST_SCAN && slot_cnt_reg != CNT_W'(MAX_BOARDS)
                     && !(slot_used_reg[cur_slot] && !slot_complete_reg[cur_slot]))
            begin
                if (!slot_used_reg[cur_slot] && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
                slot_cnt_reg <= CNT_W'(slot_cnt_reg + 1'b1);
            end
            else if (state_reg == ST_CHECK)
            begin
                if (side_hit)
                begin
                    hit_reg <= 1'b1;
                end
                else
                begin
                    slot_cnt_reg <= CNT_W'(slot_cnt_reg + 1'b1);
                end
            end

            // Commit: update slot flags and id counter, load the result.
            if (state_reg == ST_COMMIT && can_load)
            begin
                if (hit_reg)
                begin
                    slot_complete_reg[cur_slot] <= 1'b1;
                end
                else if (free_found_reg)
                begin
                    slot_used_reg[free_slot_reg]     <= 1'b1;
                    slot_complete_reg[free_slot_reg] <= 1'b0;
                    next_board_reg <= 16'(next_board_reg + 16'd1);
                end
            end

            // Result register.
            if (state_reg == ST_COMMIT && can_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Edge payload registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            is_left_reg   <= (prev_filt_reg < cur_filt);
            edge_idx_reg  <= 16'(sample_index_reg - 16'd1);
            edge_dist_reg <= prev_raw_reg;
            pts_reg       <= (scan_points_reg == 16'd0) ? 16'd1 : scan_points_reg;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= 32'(edge_idx_reg) * 32'(FULL_TURN_CDEG);
        end
        if (state_reg == ST_DIV && div_status.done)
        begin
            angle_reg <= quo_sat;
        end
        if (state_reg == ST_SCAN && slot_cnt_reg != CNT_W'(MAX_BOARDS)
            && !slot_used_reg[cur_slot] && !free_found_reg)
        begin
            free_slot_reg <= cur_slot;
        end
        if (state_reg == ST_COMMIT && can_load)
        begin
            out_data_reg <= result;
        end
    end

`ifndef ASSERT_OFF
    // A slot can only be complete once it holds a board.
    assert property (@(posedge clk) disable iff (!rst_n)
        (slot_complete_reg & ~slot_used_reg) == '0)
        else $error("complete flag set on an unused slot");

    // The slot walk only reads open boards.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_rd_en |-> (slot_used_reg[mem_addr] && !slot_complete_reg[mem_addr]))
        else $error("slot memory read of an empty or completed slot");

    // Opening a board advances the id counter by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT && can_load && !hit_reg && free_found_reg)
        |=> next_board_reg == 16'($past(next_board_reg) + 16'd1))
        else $error("board id counter did not advance on a new board");

    // The divider only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide step");
`endif

endmodule

FILE: rtl/core/lebm_divider.sv
// Radix-2 restoring divider: 32-bit dividend by 16-bit divisor, one quotient bit per cycle.
// Uses lebm_pkg for the status struct.
module lebm_divider
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [31:0]               dividend,
    input  logic [15:0]               divisor,
    output logic [31:0]               quotient,
    output lebm_pkg::lebm_div_status_t status
);
    import lebm_pkg::*;

    logic [15:0] rem_reg;
    logic [15:0] rem_next;
    logic [31:0] quo_reg;
    logic [31:0] quo_next;
    logic [15:0] div_reg;
    logic [4:0]  count_reg;
    logic [4:0]  count_next;
    logic        busy_reg;
    logic        busy_next;
    logic        done_reg;
    logic        done_next;
    logic [16:0] trial;
    logic        fits;

    // One restoring step: shift in the next dividend bit and try the subtraction.
    always_comb
    begin
        trial      = {rem_reg, quo_reg[31]};
        fits       = (trial >= {1'b0, div_reg});
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            rem_next   = '0;
            quo_next   = dividend;
            count_next = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = 16'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[15:0];
            end
            quo_next   = {quo_reg[30:0], fits};
            count_next = 5'(count_reg + 5'd1);
            if (count_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
